/* rtl/gamepad_chord_detector_autorepeat_core_assert.svh */
// assertion macros shared by the rtl
`ifndef GAMEPAD_CHORD_DETECTOR_AUTOREPEAT_CORE_ASSERT_SVH
`define GAMEPAD_CHORD_DETECTOR_AUTOREPEAT_CORE_ASSERT_SVH

// same-cycle implication
`define GCDA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcda assertion failed");

// next-cycle implication
`define GCDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcda assertion failed");

`endif

/* rtl/gcda_pkg.sv */
package gcda_pkg;

    localparam int SLOTS         = 6;
    localparam int SLOT_VOL_UP   = 4;
    localparam int SLOT_VOL_DOWN = 5;
    localparam int VOL_SLOTS     = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE          = 3'd0,
        REG_BINDING_TABLE   = 3'd1,
        REG_TRIGGER_LEVEL   = 3'd2,
        REG_STICK_LEVEL     = 3'd3,
        REG_REPEAT_DELAY    = 3'd4,
        REG_REPEAT_INTERVAL = 3'd5
    } reg_idx_t;

    localparam logic [7:0]  TRIGGER_LEVEL_RST   = 8'd127;
    localparam logic [14:0] STICK_LEVEL_RST     = 15'd16383;
    localparam logic [15:0] REPEAT_DELAY_RST    = 16'd450;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd150;

    // modifier codes
    localparam logic [2:0] MOD_NONE = 3'd0;
    localparam logic [2:0] MOD_LB   = 3'd1;
    localparam logic [2:0] MOD_RB   = 3'd2;
    localparam logic [2:0] MOD_LT   = 3'd3;
    localparam logic [2:0] MOD_RT   = 3'd4;

    // input codes
    localparam logic [4:0] IN_A         = 5'd1;
    localparam logic [4:0] IN_B         = 5'd2;
    localparam logic [4:0] IN_X         = 5'd3;
    localparam logic [4:0] IN_Y         = 5'd4;
    localparam logic [4:0] IN_DPAD_UP   = 5'd5;
    localparam logic [4:0] IN_DPAD_DOWN = 5'd6;
    localparam logic [4:0] IN_DPAD_LEFT = 5'd7;
    localparam logic [4:0] IN_DPAD_RGT  = 5'd8;
    localparam logic [4:0] IN_L_CLICK   = 5'd9;
    localparam logic [4:0] IN_R_CLICK   = 5'd10;
    localparam logic [4:0] IN_LS_UP     = 5'd11;
    localparam logic [4:0] IN_LS_DOWN   = 5'd12;
    localparam logic [4:0] IN_LS_LEFT   = 5'd13;
    localparam logic [4:0] IN_LS_RGT    = 5'd14;
    localparam logic [4:0] IN_RS_UP     = 5'd15;
    localparam logic [4:0] IN_RS_DOWN   = 5'd16;
    localparam logic [4:0] IN_RS_LEFT   = 5'd17;
    localparam logic [4:0] IN_RS_RGT    = 5'd18;
    localparam logic [4:0] IN_LT        = 5'd19;
    localparam logic [4:0] IN_RT        = 5'd20;
    localparam logic [4:0] IN_LB        = 5'd21;
    localparam logic [4:0] IN_RB        = 5'd22;

    // button bit positions
    localparam int BIT_DPAD_UP   = 0;
    localparam int BIT_DPAD_DOWN = 1;
    localparam int BIT_DPAD_LEFT = 2;
    localparam int BIT_DPAD_RGT  = 3;
    localparam int BIT_L_THUMB   = 6;
    localparam int BIT_R_THUMB   = 7;
    localparam int BIT_LB        = 8;
    localparam int BIT_RB        = 9;
    localparam int BIT_A         = 12;
    localparam int BIT_B         = 13;
    localparam int BIT_X         = 14;
    localparam int BIT_Y         = 15;

    typedef struct packed {
        logic [15:0]        buttons;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [7:0]         lt;
        logic [7:0]         rt;
    } pad_t;

    typedef struct packed {
        logic [7:0]  trig;
        logic [14:0] stick;
    } levels_t;

    function automatic logic trig_on(logic [7:0] v, logic [7:0] lvl);
        return v >= lvl;
    endfunction

    function automatic logic pos_on(logic signed [15:0] v, logic [14:0] lvl);
        logic signed [16:0] a;
        logic signed [16:0] b;
        a = {v[15], v};
        b = {2'b00, lvl};
        return a >= b;
    endfunction

    function automatic logic neg_on(logic signed [15:0] v, logic [14:0] lvl);
        logic signed [16:0] a;
        logic signed [16:0] b;
        a = {v[15], v};
        b = -$signed({2'b00, lvl});
        return a <= b;
    endfunction

    function automatic logic modifier_on(pad_t p, logic [2:0] code, levels_t lv);
        logic r;
        r = 1'b0;
        unique case (code)
            MOD_NONE: r = 1'b1;
            MOD_LB:   r = p.buttons[BIT_LB];
            MOD_RB:   r = p.buttons[BIT_RB];
            MOD_LT:   r = trig_on(p.lt, lv.trig);
            MOD_RT:   r = trig_on(p.rt, lv.trig);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic input_on(pad_t p, logic [4:0] code, levels_t lv);
        logic r;
        r = 1'b0;
        unique case (code)
            IN_A:         r = p.buttons[BIT_A];
            IN_B:         r = p.buttons[BIT_B];
            IN_X:         r = p.buttons[BIT_X];
            IN_Y:         r = p.buttons[BIT_Y];
            IN_DPAD_UP:   r = p.buttons[BIT_DPAD_UP];
            IN_DPAD_DOWN: r = p.buttons[BIT_DPAD_DOWN];
            IN_DPAD_LEFT: r = p.buttons[BIT_DPAD_LEFT];
            IN_DPAD_RGT:  r = p.buttons[BIT_DPAD_RGT];
            IN_L_CLICK:   r = p.buttons[BIT_L_THUMB];
            IN_R_CLICK:   r = p.buttons[BIT_R_THUMB];
            IN_LS_UP:     r = pos_on(p.ly, lv.stick);
            IN_LS_DOWN:   r = neg_on(p.ly, lv.stick);
            IN_LS_LEFT:   r = neg_on(p.lx, lv.stick);
            IN_LS_RGT:    r = pos_on(p.lx, lv.stick);
            IN_RS_UP:     r = pos_on(p.ry, lv.stick);
            IN_RS_DOWN:   r = neg_on(p.ry, lv.stick);
            IN_RS_LEFT:   r = neg_on(p.rx, lv.stick);
            IN_RS_RGT:    r = pos_on(p.rx, lv.stick);
            IN_LT:        r = trig_on(p.lt, lv.trig);
            IN_RT:        r = trig_on(p.rt, lv.trig);
            IN_LB:        r = p.buttons[BIT_LB];
            IN_RB:        r = p.buttons[BIT_RB];
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/gamepad_chord_detector_autorepeat_core.sv */
// channel  dir  signals                         request
// s_       in   s_tvalid s_tready s_tdata s_tuser  one gamepad poll
// m_       out  m_tvalid m_tready m_tdata          fire and held masks
// cfg_     in   cfg_we cfg_index cfg_data          one register write
//
// one poll per cycle sustained while m_tready stays high; a poll passes through the input register,
// then the result register after the per-slot compare logic
// rst_n asynchronously clears valid flags and held flags and resets config registers to their defaults
// a stalled result register stalls the input register; s_tready stays high while the input
// register is empty or the result register is empty or being taken
`include "gamepad_chord_detector_autorepeat_core_assert.svh"

module gamepad_chord_detector_autorepeat_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms[31:0], buttons[47:32], left_x[63:48], left_y[79:64],
    // right_x[95:80], right_y[111:96], left_trig[119:112], right_trig[127:120]
    input  logic [127:0]                       s_tdata,
    // connected[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fire_mask[5:0], held_mask[11:6], zero[15:12]
    output logic [15:0]                        m_tdata,
    input  logic                               cfg_we,
    input  logic [gcda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcda_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gcda_pkg::*;

    logic                  enable_reg;
    logic [8*SLOTS-1:0]    binding_reg;
    logic [7:0]            trig_level_reg;
    logic [14:0]           stick_level_reg;
    logic [15:0]           delay_reg;
    logic [15:0]           interval_reg;

    logic                  in_valid_reg;
    logic [31:0]           in_now_reg;
    logic                  in_conn_reg;
    pad_t                  in_pad_reg;

    logic                  out_valid_reg;
    logic [SLOTS-1:0]      out_fire_reg;
    logic [SLOTS-1:0]      out_held_reg;

    logic [SLOTS-1:0]      held_flags_reg;
    logic [SLOTS-1:0]      held_flags_next;
    logic [SLOTS-1:0]      fire_next;
    logic [31:0]           press_time_reg  [VOL_SLOTS];
    logic [31:0]           repeat_time_reg [VOL_SLOTS];
    logic [31:0]           press_time_next [VOL_SLOTS];
    logic [31:0]           repeat_time_next[VOL_SLOTS];

    logic                  advance;
    logic                  load;
    logic                  process;
    levels_t               levels;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign load     = s_tvalid && s_tready;
    assign process  = in_valid_reg && advance;
    assign levels   = '{trig: trig_level_reg, stick: stick_level_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_held_reg, out_fire_reg};

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            binding_reg     <= '0;
            trig_level_reg  <= TRIGGER_LEVEL_RST;
            stick_level_reg <= STICK_LEVEL_RST;
            delay_reg       <= REPEAT_DELAY_RST;
            interval_reg    <= REPEAT_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:          enable_reg      <= cfg_data[0];
                REG_BINDING_TABLE:   binding_reg     <= cfg_data[8*SLOTS-1:0];
                REG_TRIGGER_LEVEL:   trig_level_reg  <= cfg_data[7:0];
                REG_STICK_LEVEL:     stick_level_reg <= cfg_data[14:0];
                REG_REPEAT_DELAY:    delay_reg       <= cfg_data[15:0];
                REG_REPEAT_INTERVAL: interval_reg    <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    // per-slot chord logic
    always_comb
    begin
        logic       active;
        logic [7:0] bind_byte;
        logic       down;
        logic [31:0] since_press;
        logic [31:0] since_repeat;
        int          s;

        active       = enable_reg && in_conn_reg;
        fire_next    = '0;
        held_flags_next = '0;
        for (int v = 0; v < VOL_SLOTS; v++)
        begin
            press_time_next[v]  = press_time_reg[v];
            repeat_time_next[v] = repeat_time_reg[v];
        end

        for (int i = 0; i < SLOTS; i++)
        begin
            bind_byte = binding_reg[8*i +: 8];
            down = active && modifier_on(in_pad_reg, bind_byte[7:5], levels)
                          && input_on(in_pad_reg, bind_byte[4:0], levels);
            held_flags_next[i] = down;
            fire_next[i]       = down && !held_flags_reg[i];
        end

        // auto-repeat of the volume slots
        for (int v = 0; v < VOL_SLOTS; v++)
        begin
            s = (v == 0) ? SLOT_VOL_UP : SLOT_VOL_DOWN;
            since_press  = in_now_reg - press_time_reg[v];
            since_repeat = in_now_reg - repeat_time_reg[v];
            if (held_flags_next[s] && !held_flags_reg[s])
            begin
                press_time_next[v]  = in_now_reg;
                repeat_time_next[v] = in_now_reg;
            end
            else if (held_flags_next[s] && since_press >= {16'h0000, delay_reg}
                     && since_repeat >= {16'h0000, interval_reg})
            begin
                fire_next[s]        = 1'b1;
                repeat_time_next[v] = in_now_reg;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_flags_reg <= '0;
        end
        else
        begin
            if (load)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (process)
                held_flags_reg <= held_flags_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_now_reg         <= s_tdata[31:0];
            in_conn_reg        <= s_tuser;
            in_pad_reg.buttons <= s_tdata[47:32];
            in_pad_reg.lx      <= s_tdata[63:48];
            in_pad_reg.ly      <= s_tdata[79:64];
            in_pad_reg.rx      <= s_tdata[95:80];
            in_pad_reg.ry      <= s_tdata[111:96];
            in_pad_reg.lt      <= s_tdata[119:112];
            in_pad_reg.rt      <= s_tdata[127:120];
        end
        if (process)
        begin
            out_fire_reg <= fire_next;
            out_held_reg <= held_flags_next;
            for (int v = 0; v < VOL_SLOTS; v++)
            begin
                press_time_reg[v]  <= press_time_next[v];
                repeat_time_reg[v] <= repeat_time_next[v];
            end
        end
    end

    // a slot only fires while its chord is held
    `GCDA_ASSERT_NOW(a_fire_needs_held, out_valid_reg, (out_fire_reg & ~out_held_reg) == '0)
    // disabled or disconnected polls clear the held flags
    `GCDA_ASSERT_NEXT(a_idle_clears, process && !(enable_reg && in_conn_reg),
        held_flags_reg == '0 && out_fire_reg == '0)
    // the result's held mask is the stored held state
    `GCDA_ASSERT_NEXT(a_held_matches, process, out_held_reg == held_flags_reg)
    // non-volume slots fire only on a rising edge
    `GCDA_ASSERT_NOW(a_edge_only, process,
        (fire_next[SLOT_VOL_UP-1:0] & held_flags_reg[SLOT_VOL_UP-1:0]) == '0)

endmodule
